// ----- rtl/core/sle_pkg.sv -----
`default_nettype none

package sle_pkg;

  localparam int LINE_DEPTH  = 64;
  localparam int COUNT_BITS  = 8;
  localparam int LEN_W       = 7;
  localparam int CNT_EXT_W   = COUNT_BITS + 4;
  localparam int CMP_W       = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LEN_W-1:0]      LEN_FULL  = LEN_W'(LINE_DEPTH);

  localparam logic [7:0] ASCII_BS    = 8'h08;
  localparam logic [7:0] ASCII_DEL   = 8'h7f;
  localparam logic [7:0] ASCII_ESC   = 8'h1b;
  localparam logic [7:0] ASCII_LBRK  = 8'h5b;
  localparam logic [7:0] ASCII_C     = 8'h43;
  localparam logic [7:0] ASCII_D     = 8'h44;
  localparam logic [7:0] ASCII_CR    = 8'h0d;
  localparam logic [7:0] ASCII_LF    = 8'h0a;
  localparam logic [7:0] ASCII_SEMI  = 8'h3b;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_CSI
  } mode_e;

  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_DELETE,
    CMD_RIGHT,
    CMD_LEFT,
    CMD_NEWLINE
  } cmd_op_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_WRITE,
    CELL_REMOVE
  } cell_op_e;

  typedef enum logic {
    BK_IDLE,
    BK_DELIVER
  } back_state_e;

  typedef struct packed {
    cmd_op_e               op;
    logic [7:0]            data;
    logic [COUNT_BITS-1:0] count;
    logic                  append;
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] cur;
  } bk_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/serial_line_editor_core.sv -----
`default_nettype none

// A byte's edit result passes the command queue, then the output register.
// Bytes are taken one per cycle while the two-entry command queue has room.
// The back end delivers a line byte by byte on a newline, taking no commands.
// Reset is asynchronous and active low; it empties the line and the queue.
// The line store itself is not cleared, since only held bytes are ever read.

module serial_line_editor_core
  import sle_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  kind_o,
  output logic [7:0]            line_byte_o,
  output logic [LEN_W-1:0]      echo_length_o,
  output logic [LEN_W-1:0]      echo_cursor_o,
  output logic                  last_of_line_o
);

  logic       push, push_ready, pop_valid, pop;
  cmd_t       push_cmd, pop_cmd;
  bk_status_t status;

  sle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .push_ready_i(push_ready)
  );

  sle_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_cmd_o   (pop_cmd),
    .pop_i       (pop)
  );

  sle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (pop_valid),
    .cmd_i         (pop_cmd),
    .cmd_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .line_byte_o   (line_byte_o),
    .echo_length_o (echo_length_o),
    .echo_cursor_o (echo_cursor_o),
    .last_of_line_o(last_of_line_o),
    .status_o      (status)
  );

`ifndef SYNTHESIS
  a_cursor_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.cur <= status.len) else $error("cursor beyond line end");

  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.len <= LEN_FULL) else $error("line length beyond store depth");

  a_echo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> echo_cursor_o <= echo_length_o && !last_of_line_o)
    else $error("echo result inconsistent");

  a_line_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> echo_length_o == '0 && echo_cursor_o == '0)
    else $error("line byte carries echo fields");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sle_front.sv -----
`default_nettype none

module sle_front
  import sle_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            push_o,
  output cmd_t            cmd_o,
  input  wire logic       push_ready_i
);

  mode_e                 mode_q, mode_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [7:0]            prev_q;
  logic [7:0]            ch;
  logic [CNT_EXT_W-1:0]  count_ext;
  logic [CNT_EXT_W-1:0]  count_next;
  logic                  accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign ch         = (rx_byte_i == ASCII_CR) ? ASCII_LF : rx_byte_i;
  assign count_ext  = CNT_EXT_W'(count_q);
  assign count_next = (count_ext << 3) + (count_ext << 1)
                    + CNT_EXT_W'(ch[3:0]);

  always_comb begin
    mode_d       = mode_q;
    count_d      = count_q;
    push_o       = 1'b0;
    cmd_o.op     = CMD_INSERT;
    cmd_o.data   = ch;
    cmd_o.count  = (count_q == '0) ? COUNT_BITS'(1) : count_q;
    cmd_o.append = 1'b0;
    if (accept) begin
      if (prev_q == ASCII_CR && rx_byte_i == ASCII_LF) begin
        push_o = 1'b0;
      end else if (rx_byte_i == ASCII_BS || rx_byte_i == ASCII_DEL) begin
        push_o   = 1'b1;
        cmd_o.op = CMD_DELETE;
      end else if (rx_byte_i == ASCII_ESC) begin
        mode_d = MODE_ESC;
      end else if (mode_q == MODE_ESC || mode_q == MODE_CSI) begin
        if (ch == ASCII_LF) begin
          mode_d   = MODE_NORMAL;
          push_o   = 1'b1;
          cmd_o.op = CMD_NEWLINE;
        end else if (mode_q == MODE_ESC) begin
          if (ch == ASCII_LBRK) begin
            mode_d  = MODE_CSI;
            count_d = '0;
          end else begin
            mode_d = MODE_NORMAL;
          end
        end else if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
          count_d = (count_next > CNT_EXT_W'(COUNT_MAX)) ? COUNT_MAX
                                                          : count_next[COUNT_BITS-1:0];
        end else if (ch == ASCII_SEMI) begin
          count_d = '0;
        end else begin
          mode_d = MODE_NORMAL;
          if (ch == ASCII_C) begin
            push_o   = 1'b1;
            cmd_o.op = CMD_RIGHT;
          end else if (ch == ASCII_D) begin
            push_o   = 1'b1;
            cmd_o.op = CMD_LEFT;
          end
        end
      end else if (ch == ASCII_LF) begin
        push_o       = 1'b1;
        cmd_o.op     = CMD_NEWLINE;
        cmd_o.append = 1'b1;
      end else begin
        push_o   = 1'b1;
        cmd_o.op = CMD_INSERT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      count_q <= '0;
      prev_q  <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      prev_q  <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sle_queue.sv -----
`default_nettype none

module sle_queue
  import sle_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output cmd_t      pop_cmd_o,
  input  wire logic pop_i
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sle_back.sv -----
`default_nettype none

module sle_back
  import sle_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       line_byte_o,
  output logic [LEN_W-1:0] echo_length_o,
  output logic [LEN_W-1:0] echo_cursor_o,
  output logic             last_of_line_o,
  output bk_status_t       status_o
);

  back_state_e      state_q, state_d;
  logic [7:0]       store_q [LINE_DEPTH];
  logic [LEN_W-1:0] len_q, len_d, cur_q, cur_d;
  logic             out_valid_q;
  logic             kind_q, last_q;
  logic [7:0]       byte_q;
  logic [LEN_W-1:0] elen_q, ecur_q;
  logic             free, fire;
  cell_op_e         cell_op;
  logic [LEN_W-1:0] cell_pos;
  logic [7:0]       cell_byte;
  logic             emit, emit_kind, emit_last;
  logic [7:0]       emit_byte;
  logic [LEN_W-1:0] room;
  logic [CMP_W-1:0] step_ext;

  assign free = !out_valid_q || out_ready_i;
  assign fire = (state_q == BK_IDLE) && cmd_valid_i && free;
  assign room = len_q - cur_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (fire && cmd_i.op == CMD_NEWLINE && (len_q != '0 || cmd_i.append)) begin
          state_d = BK_DELIVER;
        end
      end
      BK_DELIVER: begin
        if (len_q == '0 || (free && len_q == LEN_W'(1))) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    cell_op   = CELL_HOLD;
    cell_pos  = cur_q;
    cell_byte = cmd_i.data;
    len_d     = len_q;
    cur_d     = cur_q;
    emit      = 1'b0;
    emit_kind = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    step_ext  = '0;
    case (state_q)
      BK_IDLE: begin
        cmd_pop_o = free;
        if (fire) begin
          case (cmd_i.op)
            CMD_INSERT: begin
              if (len_q < LEN_FULL) begin
                cell_op = CELL_INSERT;
                len_d   = len_q + 1'b1;
                cur_d   = cur_q + 1'b1;
                emit    = 1'b1;
              end
            end
            CMD_DELETE: begin
              if (len_q != '0 && cur_q != '0) begin
                cell_op  = CELL_REMOVE;
                cell_pos = cur_q - 1'b1;
                len_d    = len_q - 1'b1;
                cur_d    = cur_q - 1'b1;
                emit     = 1'b1;
              end
            end
            CMD_RIGHT: begin
              step_ext = (CMP_W'(cmd_i.count) < CMP_W'(room)) ? CMP_W'(cmd_i.count)
                                                               : CMP_W'(room);
              cur_d    = cur_q + step_ext[LEN_W-1:0];
              emit     = 1'b1;
            end
            CMD_LEFT: begin
              step_ext = (CMP_W'(cmd_i.count) < CMP_W'(cur_q)) ? CMP_W'(cmd_i.count)
                                                                : CMP_W'(cur_q);
              cur_d    = cur_q - step_ext[LEN_W-1:0];
              emit     = 1'b1;
            end
            CMD_NEWLINE: begin
              cur_d = '0;
              if (cmd_i.append && len_q < LEN_FULL) begin
                cell_op   = CELL_WRITE;
                cell_pos  = len_q;
                cell_byte = ASCII_LF;
                len_d     = len_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      BK_DELIVER: begin
        if (free && len_q != '0) begin
          emit      = 1'b1;
          emit_kind = 1'b1;
          emit_byte = store_q[0];
          emit_last = (len_q == LEN_W'(1));
          cell_op   = CELL_REMOVE;
          cell_pos  = '0;
          len_d     = len_q - 1'b1;
          cur_d     = '0;
        end
      end
      default: ;
    endcase
  end

  for (genvar j = 0; j < LINE_DEPTH; j++) begin : g_cell
    logic [7:0] left_val, right_val;
    if (j == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_val = store_q[j-1];
    end
    if (j == LINE_DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner_r
      assign right_val = store_q[j+1];
    end
    always_ff @(posedge clk_i) begin
      case (cell_op)
        CELL_INSERT: begin
          if (LEN_W'(j) > cell_pos) begin
            store_q[j] <= left_val;
          end else if (LEN_W'(j) == cell_pos) begin
            store_q[j] <= cell_byte;
          end
        end
        CELL_WRITE: begin
          if (LEN_W'(j) == cell_pos) begin
            store_q[j] <= cell_byte;
          end
        end
        CELL_REMOVE: begin
          if (LEN_W'(j) >= cell_pos) begin
            store_q[j] <= right_val;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      len_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= emit_kind;
      byte_q <= emit_byte;
      last_q <= emit_last;
      elen_q <= emit_kind ? '0 : len_d;
      ecur_q <= emit_kind ? '0 : cur_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign line_byte_o    = byte_q;
  assign echo_length_o  = elen_q;
  assign echo_cursor_o  = ecur_q;
  assign last_of_line_o = last_q;
  assign status_o.len   = len_q;
  assign status_o.cur   = cur_q;

endmodule

`default_nettype wire

// ----- tb/sv/sle_result_checker.sv -----
module sle_result_checker
  import sle_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_ready_i,
  input  wire logic             kind_i,
  input  wire logic [7:0]       line_byte_i,
  input  wire logic [LEN_W-1:0] echo_length_i,
  input  wire logic [LEN_W-1:0] echo_cursor_i,
  input  wire logic             last_of_line_i,
  output int                    mismatch_count_o,
  output int                    awaited_count_o
);

  typedef struct packed {
    logic             kind;
    logic [7:0]       line_byte;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] cursor;
    logic             last;
  } edit_result_t;

  logic [7:0]   line_mem [LINE_DEPTH];
  int           line_len;
  int           line_cur;
  mode_e        parse_mode;
  int           csi_val;
  logic [7:0]   prev_rx;
  edit_result_t awaited_q [$];
  edit_result_t seen_r;
  edit_result_t want_r;
  int           mismatches;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: mismatch on %s, got %0h, wanted %0h", $time, what, got, want);
    end
  endtask

  task automatic push_echo();
    edit_result_t r;
    r = '0;
    r.length = LEN_W'(line_len);
    r.cursor = LEN_W'(line_cur);
    awaited_q.push_back(r);
  endtask

  task automatic push_line();
    edit_result_t r;
    int i;
    for (i = 0; i < line_len; i++) begin
      r = '0;
      r.kind = 1'b1;
      r.line_byte = line_mem[i];
      r.last = (i + 1 == line_len);
      awaited_q.push_back(r);
    end
    line_len = 0;
    line_cur = 0;
  endtask

  task automatic apply_rx_byte(input logic [7:0] rx);
    logic [7:0] c;
    logic [7:0] last_rx;
    int         step;
    int         nv;
    int         i;
    last_rx = prev_rx;
    prev_rx = rx;
    c = rx;
    if (last_rx == ASCII_CR && rx == ASCII_LF) return;
    if (rx == ASCII_BS || rx == ASCII_DEL) begin
      if (line_len != 0 && line_cur != 0) begin
        for (i = line_cur - 1; i < line_len - 1; i++) line_mem[i] = line_mem[i + 1];
        line_len--;
        line_cur--;
        push_echo();
      end
      return;
    end
    if (rx == ASCII_ESC) begin
      parse_mode = MODE_ESC;
      return;
    end
    if (c == ASCII_CR) c = ASCII_LF;
    if (parse_mode == MODE_ESC || parse_mode == MODE_CSI) begin
      if (c == ASCII_LF) begin
        parse_mode = MODE_NORMAL;
        push_line();
        return;
      end
      if (parse_mode == MODE_ESC) begin
        if (c == ASCII_LBRK) begin
          parse_mode = MODE_CSI;
          csi_val = 0;
        end else begin
          parse_mode = MODE_NORMAL;
        end
        return;
      end
      if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
        nv = csi_val * 10 + int'(c - ASCII_ZERO);
        csi_val = (nv > int'(COUNT_MAX)) ? int'(COUNT_MAX) : nv;
        return;
      end
      if (c == ASCII_SEMI) begin
        csi_val = 0;
        return;
      end
      parse_mode = MODE_NORMAL;
      step = (csi_val == 0) ? 1 : csi_val;
      if (c == ASCII_C) begin
        if (line_len - line_cur < step) step = line_len - line_cur;
        line_cur += step;
        push_echo();
      end else if (c == ASCII_D) begin
        if (line_cur < step) step = line_cur;
        line_cur -= step;
        push_echo();
      end
      return;
    end
    if (c == ASCII_LF) begin
      if (line_len < LINE_DEPTH) begin
        line_mem[line_len] = c;
        line_len++;
      end
      push_line();
      return;
    end
    if (line_len >= LINE_DEPTH) return;
    for (i = line_len; i > line_cur; i--) line_mem[i] = line_mem[i - 1];
    line_mem[line_cur] = c;
    line_len++;
    line_cur++;
    push_echo();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len = 0;
      line_cur = 0;
      parse_mode = MODE_NORMAL;
      csi_val = 0;
      prev_rx = 8'h00;
      awaited_q.delete();
      awaited_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_r.kind = kind_i;
        seen_r.line_byte = line_byte_i;
        seen_r.length = echo_length_i;
        seen_r.cursor = echo_cursor_i;
        seen_r.last = last_of_line_i;
        if (awaited_q.size() == 0) begin
          report_mismatch("result with none awaited", int'(seen_r), 0);
        end else begin
          want_r = awaited_q.pop_front();
          if (seen_r.kind != want_r.kind)
            report_mismatch("kind", seen_r.kind, want_r.kind);
          if (seen_r.line_byte != want_r.line_byte)
            report_mismatch("line_byte", seen_r.line_byte, want_r.line_byte);
          if (seen_r.length != want_r.length)
            report_mismatch("echo_length", seen_r.length, want_r.length);
          if (seen_r.cursor != want_r.cursor)
            report_mismatch("echo_cursor", seen_r.cursor, want_r.cursor);
          if (seen_r.last != want_r.last)
            report_mismatch("last_of_line", seen_r.last, want_r.last);
        end
      end
      if (in_valid_i && in_ready_i) apply_rx_byte(rx_byte_i);
      awaited_count_o <= awaited_q.size();
    end
  end

  initial mismatches = 0;

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import sle_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       rx_byte;
  logic             out_valid;
  logic             out_ready;
  logic             kind;
  logic [7:0]       line_byte;
  logic [LEN_W-1:0] echo_length;
  logic [LEN_W-1:0] echo_cursor;
  logic             last_of_line;
  int               mismatch_count;
  int               awaited_count;
  int               bytes_sent;
  bit               no_idle;

  always #6 clk_i = ~clk_i;

  serial_line_editor_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .line_byte_o    (line_byte),
    .echo_length_o  (echo_length),
    .echo_cursor_o  (echo_cursor),
    .last_of_line_o (last_of_line)
  );

  sle_result_checker edit_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .kind_i           (kind),
    .line_byte_i      (line_byte),
    .echo_length_i    (echo_length),
    .echo_cursor_i    (echo_cursor),
    .last_of_line_i   (last_of_line),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(126, 32));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text();
    int n;
    n = $urandom_range(8, 1);
    repeat (n) send_byte(text_byte());
  endtask

  task automatic send_cursor_move();
    int groups;
    int digits;
    int g;
    int roll;
    send_byte(ASCII_ESC);
    send_byte(ASCII_LBRK);
    groups = $urandom_range(2);
    for (g = 0; g < groups; g++) begin
      if (g > 0) send_byte(ASCII_SEMI);
      digits = ($urandom_range(3) == 0) ? 3 : 1;
      repeat (digits) send_byte(ASCII_ZERO + 8'($urandom_range(9)));
    end
    roll = $urandom_range(9);
    if (roll == 0) send_byte(text_byte());
    else if (roll < 5) send_byte(ASCII_C);
    else send_byte(ASCII_D);
  endtask

  task automatic send_erase();
    int n;
    n = $urandom_range(3, 1);
    repeat (n) send_byte($urandom_range(1) ? ASCII_BS : ASCII_DEL);
  endtask

  task automatic send_newline();
    case ($urandom_range(4))
      0: send_byte(ASCII_CR);
      1: send_byte(ASCII_LF);
      2: begin
        send_byte(ASCII_CR);
        send_byte(ASCII_LF);
      end
      3: begin
        send_byte(ASCII_LF);
        send_byte(ASCII_LF);
      end
      default: begin
        send_byte(ASCII_CR);
        send_byte(ASCII_CR);
      end
    endcase
  endtask

  task automatic send_broken_escape();
    send_byte(ASCII_ESC);
    case ($urandom_range(4))
      0: send_byte(text_byte());
      1: begin
        send_byte(ASCII_LBRK);
        send_byte($urandom_range(1) ? ASCII_CR : ASCII_LF);
      end
      2: begin
        send_byte(ASCII_LBRK);
        send_byte(ASCII_ZERO + 8'($urandom_range(9)));
        send_byte(ASCII_ESC);
        send_byte(ASCII_LBRK);
        send_byte(ASCII_C);
      end
      3: begin
        send_byte(ASCII_BS);
        send_byte(ASCII_LBRK);
        send_byte(ASCII_D);
      end
      default: send_byte(ASCII_LF);
    endcase
  endtask

  task automatic fill_line();
    int n;
    n = $urandom_range(72, 62);
    repeat (n) send_byte(8'($urandom_range(126, 32)));
    if ($urandom_range(1)) send_cursor_move();
    case ($urandom_range(2))
      0: send_byte(ASCII_CR);
      1: begin
        send_byte(ASCII_ESC);
        send_byte(ASCII_LF);
      end
      default: begin
        send_byte(ASCII_DEL);
        send_byte(ASCII_LF);
      end
    endcase
  endtask

  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      gap = pick_gap();
      if (gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready <= 1'b1;
      end
      @(posedge clk_i);
    end
  end

  initial begin
    #40000000;
    $display("FAIL serial_line_editor_core");
    $finish;
  end

  initial begin
    bit filled;
    int roll;
    filled = 1'b0;
    bytes_sent = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(ASCII_BS);
    send_byte(8'h41);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(ASCII_DEL);
    send_byte(ASCII_ESC);
    send_byte(ASCII_LBRK);
    send_byte(ASCII_ZERO + 8'd7);
    send_byte(ASCII_SEMI);
    send_byte(ASCII_D);
    send_byte(ASCII_ESC);
    send_byte(ASCII_LBRK);
    send_byte(ASCII_NINE);
    send_byte(ASCII_NINE);
    send_byte(ASCII_NINE);
    send_byte(ASCII_C);
    send_byte(ASCII_CR);
    send_byte(ASCII_LF);
    send_byte(ASCII_LF);
    send_byte(8'h42);
    send_byte(ASCII_ESC);
    send_byte(ASCII_LBRK);
    send_byte(8'h71);
    send_byte(ASCII_ESC);
    send_byte(ASCII_LF);

    while (bytes_sent < 130) begin
      if (!filled && bytes_sent > 30) begin
        fill_line();
        filled = 1'b1;
      end
      if ($urandom_range(7) == 0) no_idle = !no_idle;
      roll = $urandom_range(99);
      if (roll < 40) send_text();
      else if (roll < 55) send_cursor_move();
      else if (roll < 65) send_erase();
      else if (roll < 77) send_newline();
      else if (roll < 90) send_broken_escape();
      else send_byte(8'($urandom_range(255)));
    end

    no_idle = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS serial_line_editor_core");
    end else begin
      $display("FAIL serial_line_editor_core");
    end
    $finish;
  end

endmodule

// ----- serial_line_editor_core.f -----
rtl/core/sle_pkg.sv
rtl/core/sle_front.sv
rtl/core/sle_queue.sv
rtl/core/sle_back.sv
rtl/core/serial_line_editor_core.sv
tb/sv/sle_result_checker.sv
tb/sv/tb.sv
